>>> sv/assert_macros.svh
// Assertion macros shared by the PPM decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define PPSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true outside reset
`define PPSD_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> sv/ppsd_pkg.sv
// Types and constants shared by the PPM P6 stream decoder
`default_nettype none
package ppsd_pkg;

  localparam int SIDE_BITS_DEF   = 13;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int unsigned SIDE_CAP = 4096;
  localparam logic [12:0] MAX_SIDE_RESET = 13'd4096;
  localparam logic [15:0] NUM_SAT = 16'hFFFF;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  // character codes
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_MAGIC     = 2'd0;
  localparam logic [1:0] ERR_MISSING   = 2'd1;
  localparam logic [1:0] ERR_SIZE      = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  // classified input word
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       is_digit;
    logic       is_ws;
    logic       is_hash;
    logic       is_lf;
    logic       is_p;
    logic       is_6;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] argb;
    logic [23:0] pixel_index;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [1:0]  error_code;
    logic        final_pixel;
  } res_t;

endpackage
`default_nettype wire

>>> sv/ppm_p6_stream_decoder_top.sv
// Binary PPM stream decoder: one file byte in per word, header, pixels or error out.
// A result passes the front register, the word queue and the result register on its way to out_*.
// Throughput: one byte per cycle without output stalls; the back end retires one queued byte a cycle.
// Backpressure on the output fills the word queue before in_tready drops.
// Reset (synchronous, rst_n low) clears the front stage, word queue and parser, max_side returns to 4096.
`default_nettype none
module ppm_p6_stream_decoder_top #(
  parameter int SIDE_BITS   = ppsd_pkg::SIDE_BITS_DEF,
  parameter int QUEUE_DEPTH = ppsd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_wdata,     // max_side
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // data_byte
  input  wire logic        in_tlast,      // end_of_file
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,     // argb, pixel_index, image_width, image_height,
                                          // error_code, zero pad
  output logic [1:0]       out_tuser,     // kind
  output logic             out_tlast      // final_pixel
);

  logic             q_ready, q_push, q_valid, q_pop;
  ppsd_pkg::entry_t push_entry, pop_entry;
  ppsd_pkg::res_t   res;

  ppsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  ppsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (pop_entry)
  );

  ppsd_back #(
    .SIDE_BITS (SIDE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {4'd0, res.error_code, res.image_height, res.image_width,
                      res.pixel_index, res.argb};
  assign out_tuser = res.kind;
  assign out_tlast = res.final_pixel;

endmodule
`default_nettype wire

>>> sv/ppsd_front.sv
// Input stage: takes stream words, classifies the byte and hands it to the queue
`default_nettype none
module ppsd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [7:0]      in_tdata,
  input  wire logic            in_tlast,
  input  wire logic            q_ready,
  output logic                 q_push,
  output ppsd_pkg::entry_t     q_entry
);

  logic             front_v_r;
  ppsd_pkg::entry_t entry_r;
  ppsd_pkg::entry_t entry_nxt;

  assign in_tready = !front_v_r || q_ready;
  assign q_push    = front_v_r && q_ready;
  assign q_entry   = entry_r;

  always_comb begin
    entry_nxt.data     = in_tdata;
    entry_nxt.eof      = in_tlast;
    entry_nxt.is_digit = (in_tdata >= ppsd_pkg::CH_0) && (in_tdata <= ppsd_pkg::CH_9);
    entry_nxt.is_ws    = in_tdata <= ppsd_pkg::CH_SPACE;
    entry_nxt.is_hash  = in_tdata == ppsd_pkg::CH_HASH;
    entry_nxt.is_lf    = in_tdata == ppsd_pkg::CH_LF;
    entry_nxt.is_p     = in_tdata == ppsd_pkg::CH_P;
    entry_nxt.is_6     = in_tdata == ppsd_pkg::CH_6;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (in_tready) begin
      front_v_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      entry_r <= entry_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/ppsd_queue.sv
// Short word queue between the classifying front and the parsing back end
`default_nettype none
`include "assert_macros.svh"
module ppsd_queue #(
  parameter int DEPTH = ppsd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ppsd_pkg::entry_t  push_entry,
  output logic                   push_ready,
  input  wire logic              pop,
  output logic                   pop_valid,
  output ppsd_pkg::entry_t       pop_entry
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  ppsd_pkg::entry_t      mem_r [DEPTH];
  logic [PtrW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]       count_r;

  assign push_ready = count_r != CntW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_entry  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CntW'(1);
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  `PPSD_ASSERT_NEVER(a_count_bound, count_r > CntW'(DEPTH), "queue count above depth")
  `PPSD_ASSERT_NEVER(a_pop_empty, pop && (count_r == '0), "pop from empty queue")

endmodule
`default_nettype wire

>>> sv/ppsd_back.sv
// Parser back end: header state machine, pixel packing and result register
`default_nettype none
`include "assert_macros.svh"
module ppsd_back #(
  parameter int SIDE_BITS = ppsd_pkg::SIDE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [12:0]       cfg_wdata,
  input  wire logic              q_valid,
  input  wire ppsd_pkg::entry_t  q_entry,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ppsd_pkg::res_t         out_res
);

  localparam int unsigned SideMax = (1 << SIDE_BITS) - 1;
  localparam int TotW = 2 * SIDE_BITS;
  localparam int CmpW = (TotW > 25) ? TotW : 25;

  typedef enum logic [2:0] {
    PH_MAGIC0, PH_MAGIC1, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS, PH_DONE
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [15:0]          num_r, num_nxt;
  logic                 started_r, started_nxt;
  logic                 comment_r, comment_nxt;
  logic [SIDE_BITS-1:0] width_r, width_nxt;
  logic [SIDE_BITS-1:0] height_r, height_nxt;
  logic [23:0]          count_r, count_nxt;
  logic [1:0]           lane_r, lane_nxt;
  logic [7:0]           red_r, red_nxt;
  logic [7:0]           green_r, green_nxt;
  logic [TotW-1:0]      total_r;
  logic [12:0]          max_side_r;
  logic                 out_v_r;
  ppsd_pkg::res_t       out_r;

  logic                 res_v;
  ppsd_pkg::res_t       res;

  logic                 handled, do_skip;
  logic                 finish_req, finish_eof;
  logic                 fail_req;
  logic [1:0]           fail_code;
  logic [19:0]          num_ext;
  logic [SIDE_BITS-1:0] side_v;
  logic [16:0]          lim;
  logic                 size_ok;
  logic                 last_pix;
  ppsd_pkg::entry_t     e;

  assign e         = q_entry;
  assign q_pop     = q_valid && (!out_v_r || out_ready);
  assign out_valid = out_v_r;
  assign out_res   = out_r;

  always_comb begin
    lim = 17'(max_side_r);
    if (lim > 17'(ppsd_pkg::SIDE_CAP)) lim = 17'(ppsd_pkg::SIDE_CAP);
    if (lim > 17'(SideMax)) lim = 17'(SideMax);
    size_ok = (width_r != '0) && (17'(width_r) <= lim) &&
              (height_r != '0) && (17'(height_r) <= lim);
  end

  assign num_ext  = 20'(num_r) * 20'd10 + 20'(e.data[3:0]);
  assign side_v   = (32'(num_r) > 32'(SideMax)) ? SIDE_BITS'(SideMax) : SIDE_BITS'(num_r);
  assign last_pix = (CmpW'(count_r) + CmpW'(1)) >= CmpW'(total_r);

  always_comb begin
    phase_nxt   = phase_r;
    num_nxt     = num_r;
    started_nxt = started_r;
    comment_nxt = comment_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    count_nxt   = count_r;
    lane_nxt    = lane_r;
    red_nxt     = red_r;
    green_nxt   = green_r;
    res_v       = 1'b0;
    res         = '0;
    handled     = 1'b0;
    do_skip     = 1'b0;
    finish_req  = 1'b0;
    finish_eof  = 1'b0;
    fail_req    = 1'b0;
    fail_code   = ppsd_pkg::ERR_MAGIC;

    unique case (phase_r)
      PH_MAGIC0: begin
        if (!e.is_p) begin
          fail_req = 1'b1;
        end else begin
          phase_nxt = PH_MAGIC1;
          fail_req  = e.eof;
        end
      end
      PH_MAGIC1: begin
        if (!e.is_6) begin
          fail_req = 1'b1;
        end else begin
          phase_nxt = PH_WIDTH;
          fail_req  = e.eof;
          fail_code = ppsd_pkg::ERR_MISSING;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        if (started_r && e.is_digit) begin
          num_nxt = (num_ext > 20'(ppsd_pkg::NUM_SAT)) ? ppsd_pkg::NUM_SAT : num_ext[15:0];
        end else if (started_r) begin
          started_nxt = 1'b0;
          num_nxt     = '0;
          if (phase_r == PH_MAXVAL) begin
            finish_req = 1'b1;
            finish_eof = e.eof;
            handled    = 1'b1;
          end else begin
            if (phase_r == PH_WIDTH) begin
              width_nxt = side_v;
              phase_nxt = PH_HEIGHT;
            end else begin
              height_nxt = side_v;
              phase_nxt  = PH_MAXVAL;
            end
            do_skip = 1'b1;
          end
        end else begin
          do_skip = 1'b1;
        end
        // whitespace and comment skipping ahead of a number
        if (do_skip) begin
          priority if (comment_r) begin
            if (e.is_lf) comment_nxt = 1'b0;
          end else if (e.is_hash) begin
            comment_nxt = 1'b1;
          end else if (e.is_ws) begin
            comment_nxt = 1'b0;
          end else if (e.is_digit) begin
            started_nxt = 1'b1;
            num_nxt     = 16'(e.data[3:0]);
          end else begin
            fail_req  = 1'b1;
            fail_code = ppsd_pkg::ERR_MISSING;
            handled   = 1'b1;
          end
        end
        if (!handled && e.eof) begin
          if (phase_nxt == PH_MAXVAL && started_nxt) begin
            finish_req = 1'b1;
            finish_eof = 1'b1;
          end else begin
            fail_req  = 1'b1;
            fail_code = ppsd_pkg::ERR_MISSING;
          end
        end
      end
      PH_PIXELS: begin
        unique case (lane_r)
          2'd0: begin
            red_nxt   = e.data;
            lane_nxt  = 2'd1;
            fail_req  = e.eof;
            fail_code = ppsd_pkg::ERR_TRUNCATED;
          end
          2'd1: begin
            green_nxt = e.data;
            lane_nxt  = 2'd2;
            fail_req  = e.eof;
            fail_code = ppsd_pkg::ERR_TRUNCATED;
          end
          default: begin
            lane_nxt = 2'd0;
            res.kind = ppsd_pkg::KIND_PIXEL;
            res.argb = {ppsd_pkg::ALPHA_OPAQUE, red_r, green_r, e.data};
            res.pixel_index = count_r;
            if (last_pix) begin
              phase_nxt       = PH_DONE;
              res_v           = 1'b1;
              res.final_pixel = 1'b1;
            end else if (e.eof) begin
              fail_req  = 1'b1;
              fail_code = ppsd_pkg::ERR_TRUNCATED;
            end else begin
              count_nxt = count_r + 24'd1;
              res_v     = 1'b1;
            end
          end
        endcase
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    if (finish_req) begin
      if (!size_ok) begin
        fail_req  = 1'b1;
        fail_code = ppsd_pkg::ERR_SIZE;
      end else if (finish_eof) begin
        fail_req  = 1'b1;
        fail_code = ppsd_pkg::ERR_TRUNCATED;
      end else begin
        phase_nxt        = PH_PIXELS;
        count_nxt        = '0;
        lane_nxt         = 2'd0;
        res_v            = 1'b1;
        res              = '0;
        res.kind         = ppsd_pkg::KIND_HEADER;
        res.image_width  = 13'(width_r);
        res.image_height = 13'(height_r);
      end
    end

    if (fail_req) begin
      phase_nxt      = PH_DONE;
      res_v          = 1'b1;
      res            = '0;
      res.kind       = ppsd_pkg::KIND_ERROR;
      res.error_code = fail_code;
    end

    // last byte of a file: back to the start for the next one
    if (e.eof) begin
      phase_nxt   = PH_MAGIC0;
      num_nxt     = '0;
      started_nxt = 1'b0;
      comment_nxt = 1'b0;
      width_nxt   = '0;
      height_nxt  = '0;
      count_nxt   = '0;
      lane_nxt    = 2'd0;
      red_nxt     = '0;
      green_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_MAGIC0;
      num_r      <= '0;
      started_r  <= 1'b0;
      comment_r  <= 1'b0;
      width_r    <= '0;
      height_r   <= '0;
      count_r    <= '0;
      lane_r     <= 2'd0;
      red_r      <= '0;
      green_r    <= '0;
      total_r    <= '0;
      max_side_r <= ppsd_pkg::MAX_SIDE_RESET;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_side_r <= cfg_wdata;
      end
      // pixel total settles long before the first pixel word arrives
      total_r <= TotW'(width_r) * TotW'(height_r);
      if (q_pop) begin
        phase_r   <= phase_nxt;
        num_r     <= num_nxt;
        started_r <= started_nxt;
        comment_r <= comment_nxt;
        width_r   <= width_nxt;
        height_r  <= height_nxt;
        count_r   <= count_nxt;
        lane_r    <= lane_nxt;
        red_r     <= red_nxt;
        green_r   <= green_nxt;
      end
      if (!out_v_r || out_ready) begin
        out_v_r <= q_pop && res_v;
      end
    end
    if (q_pop && res_v) begin
      out_r <= res;
    end
  end

  `PPSD_ASSERT(a_lane_in_pixels, (lane_r != 2'd0) |-> (phase_r == PH_PIXELS), "lane outside pixels")
  `PPSD_ASSERT_NEVER(a_lane_range, lane_r == 2'd3, "byte lane out of range")
  `PPSD_ASSERT(a_header_to_pixels, (q_pop && res_v && (res.kind == ppsd_pkg::KIND_HEADER)) |=> (phase_r == PH_PIXELS), "header did not enter pixel phase")

endmodule
`default_nettype wire
